// ===== design/periodic_timer_multiplexer_unit_assert.svh =====
// Assertion macros used by the periodic timer multiplexer datapath.
// No dependencies; include by bare file name.
`ifndef PERIODIC_TIMER_MULTIPLEXER_UNIT_ASSERT_SVH
`define PERIODIC_TIMER_MULTIPLEXER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PTM_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ptm: assertion failed");

// next-cycle implication, disabled in reset
`define PTM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ptm: assertion failed");

`endif

// ===== design/ptm_pkg.sv =====
// Types and constants of the periodic timer multiplexer.
// No dependencies; imported by every module of the block.
package ptm_pkg;

    localparam int PTM_MAX_TIMERS = 16;
    localparam int TTG_W = 34;
    localparam logic signed [TTG_W-1:0] PTM_FIRE_LIMIT = 34'sd1000000;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_ADD  = 2'd1,
        FUNC_DEL  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FIRE,
        S_ADD,
        S_SCAN2,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] period;
        logic [31:0] last;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clr_min;
        logic scan_run;
        logic fire_en;
        logic match_en;
        logic fire_wr;
        logic add_wr;
        logic move_rd;
        logic move_wr;
        logic count_dec;
        logic set_full;
        logic set_absent;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       count_zero;
        logic       count_full;
        logic       scan_done;
        logic       found;
        logic       move_more;
        logic       out_free;
    } t_stat;

endpackage

// ===== design/ptm_ctrl.sv =====
// Sequencer of the periodic timer multiplexer: scan, fire, add, compact.
// Depends on ptm_pkg.
module ptm_ctrl import ptm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    FUNC_TICK: n_state = i_stat.count_zero ? S_DONE : S_SCAN;
                    FUNC_ADD:  n_state = i_stat.count_full ? S_DONE : S_ADD;
                    FUNC_DEL:  n_state = S_SCAN;
                    default:   n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    if (i_stat.found && i_stat.func == FUNC_TICK) begin
                        n_state = S_FIRE;
                    end else if (i_stat.found && i_stat.func == FUNC_DEL) begin
                        n_state = S_MOVE_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIRE:    n_state = S_SCAN2;
            S_ADD:     n_state = S_SCAN2;
            S_SCAN2: begin
                if (i_stat.scan_done) n_state = S_DONE;
            end
            S_MOVE_RD: n_state = i_stat.move_more ? S_MOVE_WR : S_DONE;
            S_MOVE_WR: n_state = S_MOVE_RD;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.load  = i_in_valid;
            end
            S_DISPATCH: begin
                o_cmd.set_full = (i_stat.func == FUNC_ADD) && i_stat.count_full;
            end
            S_SCAN: begin
                o_cmd.scan_run   = 1'b1;
                o_cmd.fire_en    = (i_stat.func == FUNC_TICK);
                o_cmd.match_en   = (i_stat.func == FUNC_DEL);
                o_cmd.set_absent = i_stat.scan_done && !i_stat.found
                                   && (i_stat.func == FUNC_DEL);
            end
            S_FIRE: begin
                o_cmd.fire_wr = 1'b1;
                o_cmd.clr_min = 1'b1;
            end
            S_ADD: begin
                o_cmd.add_wr  = 1'b1;
                o_cmd.clr_min = 1'b1;
            end
            S_SCAN2: begin
                o_cmd.scan_run = 1'b1;
            end
            S_MOVE_RD: begin
                o_cmd.move_rd   = 1'b1;
                o_cmd.count_dec = !i_stat.move_more;
            end
            S_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== design/ptm_datapath.sv =====
// Timer table memory, scan pipeline, min/fire trackers and result register.
// Depends on ptm_pkg and periodic_timer_multiplexer_unit_assert.svh.
`include "periodic_timer_multiplexer_unit_assert.svh"
module ptm_datapath import ptm_pkg::*; #(
    parameter int MAX_TIMERS = PTM_MAX_TIMERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_timer_id,
    input  logic [31:0] i_period_ms,
    input  logic [31:0] i_now_ms,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic        o_fired_valid,
    output logic [15:0] o_fired_id,
    output logic        o_countdown_set,
    output logic [31:0] o_countdown_ms
);

    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TIMERS);

    t_entry mem [MAX_TIMERS];

    // latched word
    logic [1:0]  r_func;
    logic [15:0] r_id;
    logic [31:0] r_period;
    logic [31:0] r_now;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_addr;

    // scan pipeline: read -> time-to-go -> trackers
    logic                    r_v1;
    logic                    r_v2;
    logic [IW-1:0]           r_idx1;
    logic [IW-1:0]           r_idx2;
    t_entry                  r_rd;
    logic signed [TTG_W-1:0] r_ttg;
    logic [15:0]             r_id2;
    logic [31:0]             r_per2;

    logic signed [TTG_W-1:0] r_min;
    logic                    r_min_first;
    logic signed [TTG_W-1:0] r_best;
    logic                    r_found;
    logic [IW-1:0]           r_sel;
    logic [15:0]             r_sel_id;
    logic [31:0]             r_sel_per;
    t_status                 r_status;

    logic                    r_out_valid;
    logic [1:0]              r_o_status;
    logic                    r_o_fired_valid;
    logic [15:0]             r_o_fired_id;
    logic                    r_o_cd_set;
    logic [31:0]             r_o_cd;

    logic                    issue;
    logic [31:0]             elapsed;
    logic signed [TTG_W-1:0] ttg_n;
    logic [CW-1:0]           sel_next;
    logic                    move_more;
    logic [IW-1:0]           rd_addr;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    t_entry                  wr_data;
    logic [31:0]             cd_val;
    logic                    out_free;

    assign issue     = i_cmd.scan_run && (r_addr != r_count);
    assign elapsed   = r_now - r_rd.last;
    assign ttg_n     = $signed({2'b00, r_rd.period}) - $signed({2'b00, elapsed});
    assign sel_next  = CW'(r_sel) + CW'(1);
    assign move_more = (sel_next < r_count);
    assign out_free  = !r_out_valid || i_out_ready;

    assign rd_addr = i_cmd.move_rd ? sel_next[IW-1:0] : r_addr[IW-1:0];

    always_comb begin
        wr_en   = i_cmd.fire_wr || i_cmd.add_wr || i_cmd.move_wr;
        wr_addr = r_sel;
        wr_data = r_rd;
        if (i_cmd.add_wr) begin
            wr_addr = r_count[IW-1:0];
            wr_data = '{id: r_id, period: r_period, last: r_now};
        end else if (i_cmd.fire_wr) begin
            wr_data = '{id: r_sel_id, period: r_sel_per, last: r_now};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (i_cmd.add_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_addr[IW-1:0];
        r_idx2 <= r_idx1;
        r_ttg  <= ttg_n;
        r_id2  <= r_rd.id;
        r_per2 <= r_rd.period;

        if (i_cmd.load) begin
            r_func      <= i_func;
            r_id        <= i_timer_id;
            r_period    <= i_period_ms;
            r_now       <= i_now_ms;
            r_addr      <= '0;
            r_min_first <= 1'b1;
            r_found     <= 1'b0;
            r_best      <= PTM_FIRE_LIMIT;
            r_status    <= STAT_OK;
        end else begin
            if (i_cmd.clr_min) begin
                r_addr      <= '0;
                r_min_first <= 1'b1;
            end else if (issue) begin
                r_addr <= r_addr + CW'(1);
            end

            if (r_v2 && (r_min_first || r_ttg < r_min)) begin
                r_min       <= r_ttg;
                r_min_first <= 1'b0;
            end

            // strict compare keeps the earliest entry on ties
            if (r_v2 && i_cmd.fire_en && r_ttg < r_best) begin
                r_best    <= r_ttg;
                r_found   <= 1'b1;
                r_sel     <= r_idx2;
                r_sel_id  <= r_id2;
                r_sel_per <= r_per2;
            end

            if (r_v2 && i_cmd.match_en && !r_found && r_id2 == r_id) begin
                r_found <= 1'b1;
                r_sel   <= r_idx2;
            end

            if (i_cmd.move_wr) begin
                r_sel <= sel_next[IW-1:0];
            end

            if (i_cmd.set_full) begin
                r_status <= STAT_FULL;
            end else if (i_cmd.set_absent) begin
                r_status <= STAT_ABSENT;
            end
        end
    end

    // overdue saturates to zero
    assign cd_val = (r_min_first || r_min[TTG_W-1]) ? 32'd0 : r_min[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status      <= r_status;
            r_o_fired_valid <= 1'b0;
            r_o_fired_id    <= '0;
            r_o_cd_set      <= 1'b0;
            r_o_cd          <= '0;
            case (r_func)
                FUNC_TICK: begin
                    r_o_fired_valid <= r_found;
                    r_o_fired_id    <= r_found ? r_sel_id : 16'd0;
                    r_o_cd_set      <= !r_min_first;
                    r_o_cd          <= cd_val;
                end
                FUNC_ADD: begin
                    r_o_cd_set <= (cd_val != 32'd0);
                    r_o_cd     <= cd_val;
                end
                default: ;
            endcase
        end
    end

    assign o_stat = '{func: r_func, count_zero: (r_count == '0),
                      count_full: (r_count >= MAX_CNT), scan_done: (!issue && !r_v1 && !r_v2),
                      found: r_found, move_more: move_more, out_free: out_free};

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_fired_valid   = r_o_fired_valid;
    assign o_fired_id      = r_o_fired_id;
    assign o_countdown_set = r_o_cd_set;
    assign o_countdown_ms  = r_o_cd;

    `PTM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MAX_CNT)
    `PTM_ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || i_out_ready)
    `PTM_ASSERT_IMP(a_move_range, i_clk, i_rst_n, i_cmd.move_wr, move_more)
    `PTM_ASSERT_IMP(a_fire_cd, i_clk, i_rst_n, r_out_valid && r_o_fired_valid, r_o_cd_set)
    `PTM_ASSERT_NEXT(a_wr_quiet, i_clk, i_rst_n, i_cmd.add_wr || i_cmd.fire_wr, !r_v1 && !r_v2)

endmodule

// ===== design/periodic_timer_multiplexer_unit.sv =====
// Top level of the periodic timer multiplexer: sequencer plus datapath.
// Depends on ptm_pkg, ptm_ctrl and ptm_datapath.
//
//  channel  valid         ready         payload
//  -------  ------------  ------------  -------------------------------------------
//  in       i_in_valid    o_in_ready    i_func i_timer_id i_period_ms i_now_ms
//  out      o_out_valid   i_out_ready   o_status o_fired_valid o_fired_id
//                                       o_countdown_set o_countdown_ms
//
// A tick that fires scans the table twice and an add scans it after the write;
// a delete scans for the id, then moves each later entry down by one slot.
// One word is in flight at a time; the next is taken once the result is in the
// output register, even while that result waits for i_out_ready.
// Reset clears the entry count and the handshake state; table contents are
// undefined until written.
module periodic_timer_multiplexer_unit import ptm_pkg::*; #(
    parameter int MAX_TIMERS = PTM_MAX_TIMERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_timer_id,
    input  logic [31:0] i_period_ms,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_fired_valid,
    output logic [15:0] o_fired_id,
    output logic        o_countdown_set,
    output logic [31:0] o_countdown_ms
);

    t_cmd  cmd;
    t_stat stat;

    ptm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptm_datapath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_func          (i_func),
        .i_timer_id      (i_timer_id),
        .i_period_ms     (i_period_ms),
        .i_now_ms        (i_now_ms),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_fired_valid   (o_fired_valid),
        .o_fired_id      (o_fired_id),
        .o_countdown_set (o_countdown_set),
        .o_countdown_ms  (o_countdown_ms)
    );

endmodule

// ===== tb/sv/periodic_timer_multiplexer_unit_tb.sv =====
// Testbench for periodic_timer_multiplexer_unit: directed and random timer traffic,
// a scoreboard fed by an in-bench timer table predictor. Depends on ptm_pkg.
module periodic_timer_multiplexer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptm_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 5000;
    localparam int         MAX_REPORTS = 10;

    typedef struct {
        t_status     status;
        logic        fired_valid;
        logic [15:0] fired_id;
        logic        cd_set;
        logic [31:0] cd_ms;
    } t_timer_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [15:0] i_timer_id;
    logic [31:0] i_period_ms;
    logic [31:0] i_now_ms;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic        o_fired_valid;
    logic [15:0] o_fired_id;
    logic        o_countdown_set;
    logic [31:0] o_countdown_ms;

    // predictor copy of the timer table
    int          tbl_count;
    logic [15:0] tbl_id   [PTM_MAX_TIMERS];
    logic [31:0] tbl_per  [PTM_MAX_TIMERS];
    logic [31:0] tbl_last [PTM_MAX_TIMERS];

    t_timer_result pending_results[$];
    int            error_count;
    int            words_sent;
    int            idle_cycles;
    int            send_idle_pct;
    int            recv_stall_pct;
    logic [31:0]   clock_ms;

    periodic_timer_multiplexer_unit DUT (.*);

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic signed [TTG_W-1:0] time_to_go(int idx, logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - tbl_last[idx];
        return $signed({2'b00, tbl_per[idx]}) - $signed({2'b00, elapsed});
    endfunction

    function automatic logic [31:0] nearest_countdown(logic [31:0] now);
        logic signed [TTG_W-1:0] best;
        logic signed [TTG_W-1:0] t;
        best = '0;
        for (int i = 0; i < tbl_count; i++) begin
            t = time_to_go(i, now);
            if (i == 0 || t < best) best = t;
        end
        if (best < 0) best = '0;
        return best[31:0];
    endfunction

    // applies one operation to the predictor table and returns the expected word
    function automatic t_timer_result predict_timer_op(logic [1:0] func, logic [15:0] id,
                                                       logic [31:0] period, logic [31:0] now);
        t_timer_result           r;
        logic signed [TTG_W-1:0] best;
        logic signed [TTG_W-1:0] t;
        logic                    found;
        int                      sel;
        r = '{STAT_OK, 1'b0, 16'd0, 1'b0, 32'd0};
        found = 1'b0;
        sel = 0;
        case (func)
            FUNC_TICK: begin
                if (tbl_count > 0) begin
                    best = PTM_FIRE_LIMIT;
                    for (int i = 0; i < tbl_count; i++) begin
                        t = time_to_go(i, now);
                        if (t < best) begin
                            best = t;
                            sel = i;
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        tbl_last[sel] = now;
                        r.fired_valid = 1'b1;
                        r.fired_id = tbl_id[sel];
                    end
                    r.cd_ms = nearest_countdown(now);
                    r.cd_set = 1'b1;
                end
            end
            FUNC_ADD: begin
                if (tbl_count >= PTM_MAX_TIMERS) begin
                    r.status = STAT_FULL;
                end else begin
                    tbl_id[tbl_count] = id;
                    tbl_per[tbl_count] = period;
                    tbl_last[tbl_count] = now;
                    tbl_count++;
                    r.cd_ms = nearest_countdown(now);
                    r.cd_set = (r.cd_ms != 0);
                end
            end
            FUNC_DEL: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (!found && tbl_id[i] == id) begin
                        found = 1'b1;
                        sel = i;
                    end
                end
                if (found) begin
                    for (int i = sel; i + 1 < tbl_count; i++) begin
                        tbl_id[i] = tbl_id[i + 1];
                        tbl_per[i] = tbl_per[i + 1];
                        tbl_last[i] = tbl_last[i + 1];
                    end
                    tbl_count--;
                end else begin
                    r.status = STAT_ABSENT;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // one word on the input channel; the prediction is made at the accepting edge
    task automatic send_word(logic [1:0] func, logic [15:0] id, logic [31:0] period,
                             logic [31:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid  <= 1'b0;
            i_func      <= 2'($urandom);
            i_timer_id  <= 16'($urandom);
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_timer_id  <= id;
        i_period_ms <= period;
        i_now_ms    <= now;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_timer_op(func, id, period, now));
        words_sent++;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else          i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_timer_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result word status=%0d fired=%0b/%0h",
                                     o_status, o_fired_valid, o_fired_id));
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status || o_fired_valid !== exp_r.fired_valid ||
                    o_fired_id !== exp_r.fired_id || o_countdown_set !== exp_r.cd_set ||
                    o_countdown_ms !== exp_r.cd_ms)
                    note_error($sformatf({"result mismatch: exp st=%0d fv=%0b fid=%0h cs=%0b ",
                                          "cd=%0d, got st=%0d fv=%0b fid=%0h cs=%0b cd=%0d"},
                                         exp_r.status, exp_r.fired_valid, exp_r.fired_id,
                                         exp_r.cd_set, exp_r.cd_ms, o_status, o_fired_valid,
                                         o_fired_id, o_countdown_set, o_countdown_ms));
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] next_now();
        int r;
        r = $urandom_range(99);
        if (r < 78)      clock_ms += $urandom_range(0, 3000);
        else if (r < 90) clock_ms += $urandom_range(900000, 1200000);
        else if (r < 95) clock_ms = $urandom;
        else             clock_ms -= $urandom_range(0, 500);   // time going backwards
        return clock_ms;
    endfunction

    function automatic logic [31:0] random_period();
        int r;
        r = $urandom_range(99);
        if (r < 70)      return $urandom_range(0, 5000);
        else if (r < 85) return $urandom_range(990000, 1010000);   // near the fire limit
        else if (r < 95) return $urandom;
        else if (r < 98) return 32'hFFFF_FFFF;
        return 32'd0;
    endfunction

    task automatic send_tick();
        send_word(FUNC_TICK, 16'($urandom), $urandom, next_now());
    endtask

    task automatic send_add();
        logic [15:0] id;
        id = 16'($urandom);
        if (tbl_count > 0 && $urandom_range(99) < 20)
            id = tbl_id[$urandom_range(tbl_count - 1)];   // duplicate id
        send_word(FUNC_ADD, id, random_period(), next_now());
    endtask

    task automatic send_delete(bit present);
        logic [15:0] id;
        id = 16'($urandom);
        if (present && tbl_count > 0) id = tbl_id[$urandom_range(tbl_count - 1)];
        send_word(FUNC_DEL, id, $urandom, $urandom);
    endtask

    task automatic test_empty_table();
        send_word(FUNC_TICK, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_word(FUNC_DEL, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_field_extremes();
        // zero period: countdown is zero so no reload
        send_word(FUNC_ADD, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        // max period added across the wrap, first entry overdue
        send_word(FUNC_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(FUNC_TICK, 16'h1234, 32'h5555_AAAA, 32'd5);
        send_word(FUNC_DEL, 16'h0000, 32'd0, 32'd0);
        send_word(FUNC_DEL, 16'hFFFF, 32'd0, 32'd0);
    endtask

    task automatic test_tie_and_duplicates();
        send_word(FUNC_ADD, 16'd5, 32'd100, 32'd1000);
        send_word(FUNC_ADD, 16'd6, 32'd100, 32'd1000);
        send_word(FUNC_ADD, 16'd5, 32'd3000000, 32'd1000);
        // equal time-to-go: earlier entry first, then the other
        send_word(FUNC_TICK, 16'd0, 32'd0, 32'd1050);
        send_word(FUNC_TICK, 16'd0, 32'd0, 32'd1050);
        send_word(FUNC_DEL, 16'd5, 32'd0, 32'd0);   // first match only
        send_word(FUNC_DEL, 16'd6, 32'd0, 32'd0);
    endtask

    task automatic test_nothing_due();
        // remaining entry is farther out than the fire limit
        send_word(FUNC_TICK, 16'd0, 32'd0, 32'd2000);
        // overdue by a lot: fires, then reloads the full period
        send_word(FUNC_TICK, 16'd0, 32'd0, 32'd9000000);
        send_word(FUNC_ADD, 16'h00A5, 32'd10, 32'd8000000);   // entry 5 reads as overdue
        send_word(FUNC_DEL, 16'h0005, 32'd0, 32'd0);
        send_word(FUNC_DEL, 16'h00A5, 32'd0, 32'd0);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_words);
        int start;
        int kind;
        int len;
        int p;
        start = words_sent;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (words_sent - start < n_words) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                len = $urandom_range(4, 24);
                repeat (len) begin
                    p = $urandom_range(99);
                    if (p < ((tbl_count < 12) ? 40 : 15)) send_add();
                    else if (p < 80)                     send_tick();
                    else                                 send_delete($urandom_range(99) < 85);
                end
            end else if (kind < 80) begin
                // fill to full, then push past it
                while (tbl_count < PTM_MAX_TIMERS) send_add();
                repeat ($urandom_range(1, 2)) send_add();
                repeat ($urandom_range(1, 4)) send_tick();
            end else if (kind < 95) begin
                while (tbl_count > 0 && $urandom_range(99) < 90) send_delete(1'b1);
                send_delete(1'b0);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom), 16'($urandom), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_TICK;
        i_timer_id  = '0;
        i_period_ms = '0;
        i_now_ms    = '0;
        i_out_ready = 1'b0;
        tbl_count   = 0;
        error_count = 0;
        words_sent  = 0;
        idle_cycles = 0;
        clock_ms    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_field_extremes();
        test_tie_and_duplicates();
        test_nothing_due();
        test_random_traffic(0, 0, 262);
        test_random_traffic(76, 0, 262);
        test_random_traffic(0, 76, 262);
        test_random_traffic(36, 36, 262);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== periodic_timer_multiplexer_unit.f =====
+incdir+design
design/ptm_pkg.sv
design/ptm_ctrl.sv
design/ptm_datapath.sv
design/periodic_timer_multiplexer_unit.sv
tb/sv/periodic_timer_multiplexer_unit_tb.sv
